// ===== src/dsad_pkg.sv =====
package dsad_pkg;

  localparam int TIME_BITS     = 32;
  localparam int GAP_BITS      = 16;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;
  localparam int MODE_BITS     = 2;

  localparam logic [MODE_BITS-1:0] MODE_IDLE      = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FRONT_HIT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LOCKED    = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PRESS_THR   = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_THR = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_MIN     = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_MAX     = 8'd3;

  localparam logic [GAP_BITS-1:0] GAP_MIN_RESET = 16'd20;
  localparam logic [GAP_BITS-1:0] GAP_MAX_RESET = 16'd1000;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [TIME_BITS-1:0] hit_time;
  } dsad_state_t;

  typedef struct packed {
    logic [GAP_BITS-1:0] gap_min;
    logic [GAP_BITS-1:0] gap_max;
  } dsad_gap_t;

endpackage

// ===== src/dsad_step.sv =====
module dsad_step import dsad_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0] press_thr,
  input  logic [SAMPLE_BITS-1:0] release_thr,
  input  dsad_gap_t              gap,
  input  logic [SAMPLE_BITS-1:0] front,
  input  logic [SAMPLE_BITS-1:0] rear,
  input  logic [TIME_BITS-1:0]   now,
  input  dsad_state_t            cur,
  output dsad_state_t            nxt,
  output logic                   detected
);

  logic                 front_press;
  logic                 rear_press;
  logic                 all_clear;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] gap_min_w;
  logic [TIME_BITS-1:0] gap_max_w;
  logic                 past_max;
  logic                 in_window;

  assign front_press = front > press_thr;
  assign rear_press  = rear > press_thr;
  assign all_clear   = (front < release_thr) && (rear < release_thr);
  // wrapping difference: a timestamp that runs backwards reads as a long gap
  assign elapsed   = now - cur.hit_time;
  assign gap_min_w = {{(TIME_BITS-GAP_BITS){1'b0}}, gap.gap_min};
  assign gap_max_w = {{(TIME_BITS-GAP_BITS){1'b0}}, gap.gap_max};
  assign past_max  = elapsed > gap_max_w;
  assign in_window = (elapsed >= gap_min_w) && !past_max;

  always_comb begin
    nxt      = cur;
    detected = 1'b0;
    case (cur.mode)
      MODE_FRONT_HIT: begin
        if (rear_press && in_window) begin
          detected = 1'b1;
          nxt.mode = MODE_LOCKED;
        end else if (past_max) begin
          nxt.mode = MODE_LOCKED;
        end else if (!front_press && !rear_press) begin
          nxt.mode = MODE_IDLE;
        end
      end
      MODE_LOCKED: begin
        if (all_clear) begin
          nxt.mode = MODE_IDLE;
        end
      end
      default: begin
        // idle, and the unused code behaves as idle
        nxt.mode = MODE_IDLE;
        if (front_press && !rear_press) begin
          nxt.mode     = MODE_FRONT_HIT;
          nxt.hit_time = now;
        end else if (front_press && rear_press) begin
          detected = 1'b1;
          nxt.mode = MODE_LOCKED;
        end
      end
    endcase
  end

endmodule

// ===== src/dual_sensor_axle_detector_core.sv =====
// Axle detector for a pair of force sensors. Each input item is one poll (front
// sample, rear sample, millisecond timestamp) and gives exactly one result item
// (vehicle_detected, mode_now). One item is taken every cycle while in_stall is low;
// its result goes to the out_ ports through an input register and a result register
// around a single compare-and-subtract step that updates the mode and armed timestamp
// once per item. cfg_ready is always high; writes to
// indexes beyond gap_max_ms are dropped, and configuration is meant to change
// only while no item is in flight.
module dual_sensor_axle_detector_core import dsad_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_front_sample,
  input  logic [SAMPLE_BITS-1:0]   in_rear_sample,
  input  logic [TIME_BITS-1:0]     in_time_now_ms,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_vehicle_detected,
  output logic [MODE_BITS-1:0]     out_mode_now,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam logic [SAMPLE_BITS-1:0] PRESS_RESET   = SAMPLE_BITS'(2048);
  localparam logic [SAMPLE_BITS-1:0] RELEASE_RESET = SAMPLE_BITS'(1024);

  logic [SAMPLE_BITS-1:0] press_thr_r;
  logic [SAMPLE_BITS-1:0] release_thr_r;
  dsad_gap_t              gap_r;

  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_front_r;
  logic [SAMPLE_BITS-1:0] s1_rear_r;
  logic [TIME_BITS-1:0]   s1_time_r;

  dsad_state_t            state_r;
  dsad_state_t            state_nxt;
  logic                   detected_nxt;

  logic                   out_valid_r;
  logic                   out_det_r;
  logic [MODE_BITS-1:0]   out_mode_r;

  logic                   advance;
  logic                   fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_thr_r   <= PRESS_RESET;
      release_thr_r <= RELEASE_RESET;
      gap_r.gap_min <= GAP_MIN_RESET;
      gap_r.gap_max <= GAP_MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PRESS_THR:   press_thr_r   <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_RELEASE_THR: release_thr_r <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_GAP_MIN:     gap_r.gap_min <= cfg_wdata[GAP_BITS-1:0];
        CFG_GAP_MAX:     gap_r.gap_max <= cfg_wdata[GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // result register frees up when empty or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_front_r <= in_front_sample;
      s1_rear_r  <= in_rear_sample;
      s1_time_r  <= in_time_now_ms;
    end
  end

  dsad_step #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .press_thr   (press_thr_r),
    .release_thr (release_thr_r),
    .gap         (gap_r),
    .front       (s1_front_r),
    .rear        (s1_rear_r),
    .now         (s1_time_r),
    .cur         (state_r),
    .nxt         (state_nxt),
    .detected    (detected_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode     <= MODE_IDLE;
      state_r.hit_time <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_det_r  <= detected_nxt;
      out_mode_r <= state_nxt.mode;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_vehicle_detected = out_det_r;
  assign out_mode_now         = out_mode_r;

  a_det_locks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_det_r |-> out_mode_r == MODE_LOCKED)
    else $error("detection reported without locking");

  a_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_mode_r == state_r.mode)
    else $error("result mode differs from held mode");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with no item held");

  a_idle_lock_reports: assert property (@(posedge clk) disable iff (!rst_n)
    fire && state_r.mode == MODE_IDLE && state_nxt.mode == MODE_LOCKED |-> detected_nxt)
    else $error("silent lock from idle");

endmodule

// ===== tb/dual_sensor_axle_detector_core_tb.sv =====
module dual_sensor_axle_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsad_pkg::*;

  localparam int SB            = 12;
  localparam int PRESS_RESET   = 2048;
  localparam int RELEASE_RESET = 1024;
  localparam int STUCK_LIMIT   = 1000;
  localparam int PHASE_POLLS   = 275;
  localparam int HOLD_CYCLES   = 80;

  typedef struct packed {
    logic                 detected;
    logic [MODE_BITS-1:0] mode;
  } axle_report_t;

  typedef struct {
    logic [SB-1:0]        front;
    logic [SB-1:0]        rear;
    logic [TIME_BITS-1:0] now;
    logic                 check;
    axle_report_t         report;
  } axle_poll_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [SB-1:0]            in_front_sample = '0;
  logic [SB-1:0]            in_rear_sample = '0;
  logic [TIME_BITS-1:0]     in_time_now_ms = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_vehicle_detected;
  logic [MODE_BITS-1:0]     out_mode_now;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // typed-in expectation travels with the item on the wire
  logic         poll_check = 1'b0;
  axle_report_t poll_want = '0;

  // detector copy: registers and state
  logic [SB-1:0]        press_thr = SB'(PRESS_RESET);
  logic [SB-1:0]        rel_thr = SB'(RELEASE_RESET);
  logic [GAP_BITS-1:0]  gap_lo = GAP_MIN_RESET;
  logic [GAP_BITS-1:0]  gap_hi = GAP_MAX_RESET;
  logic [MODE_BITS-1:0] axle_mode = MODE_IDLE;
  logic [TIME_BITS-1:0] armed_ms = '0;

  axle_report_t axle_reports_q[$];
  axle_poll_t   directed_polls[$];

  int          mismatches = 0;
  int          polls_sent = 0;
  int          tx_pct = 0;
  int          rx_pct = 0;
  int          hold_tag = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned stuck_cycles = 0;
  logic [TIME_BITS-1:0] clock_ms = '0;

  dual_sensor_axle_detector_core #(
    .SAMPLE_BITS(SB)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_front_sample     (in_front_sample),
    .in_rear_sample      (in_rear_sample),
    .in_time_now_ms      (in_time_now_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_vehicle_detected(out_vehicle_detected),
    .out_mode_now        (out_mode_now),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic axle_report_t axle_step(input logic [SB-1:0] front,
                                             input logic [SB-1:0] rear,
                                             input logic [TIME_BITS-1:0] now);
    logic                 front_on;
    logic                 rear_on;
    logic                 both_off;
    logic [TIME_BITS-1:0] elapsed;
    axle_report_t         res;
    front_on = front > press_thr;
    rear_on  = rear > press_thr;
    both_off = (front < rel_thr) && (rear < rel_thr);
    res.detected = 1'b0;
    case (axle_mode)
      MODE_FRONT_HIT: begin
        elapsed = now - armed_ms;
        if (rear_on && elapsed >= gap_lo && elapsed <= gap_hi) begin
          res.detected = 1'b1;
          axle_mode = MODE_LOCKED;
        end else if (elapsed > gap_hi) begin
          axle_mode = MODE_LOCKED;
        end else if (!front_on && !rear_on) begin
          axle_mode = MODE_IDLE;
        end
      end
      MODE_LOCKED: begin
        if (both_off) axle_mode = MODE_IDLE;
      end
      default: begin
        // unused code 3 behaves as idle
        axle_mode = MODE_IDLE;
        if (front_on && !rear_on) begin
          axle_mode = MODE_FRONT_HIT;
          armed_ms = now;
        end else if (front_on && rear_on) begin
          res.detected = 1'b1;
          axle_mode = MODE_LOCKED;
        end
      end
    endcase
    res.mode = axle_mode;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : scoreboard
    axle_report_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = axle_step(in_front_sample, in_rear_sample, in_time_now_ms);
        if (poll_check) want = poll_want;
        axle_reports_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (axle_reports_q.size() == 0) begin
          report_mismatch("result item with none pending", out_mode_now, 0);
        end else begin
          want = axle_reports_q.pop_front();
          if (out_vehicle_detected !== want.detected)
            report_mismatch("vehicle_detected", out_vehicle_detected, want.detected);
          if (out_mode_now !== want.mode)
            report_mismatch("mode_now", out_mode_now, want.mode);
        end
      end
    end
  end

  // receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen <= hold_tag;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAIL dual_sensor_axle_detector_core");
      $finish;
    end
  end

  function automatic logic [SB-1:0] pick_sample(input int level);
    case (level)
      0: return (rel_thr == 0) ? '0 : SB'($urandom_range(rel_thr - 1, 0));
      1: return (press_thr == '1) ? '1 : SB'($urandom_range((1 << SB) - 1, press_thr + 1));
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic send_poll(input logic [SB-1:0] front, input logic [SB-1:0] rear,
                           input logic [TIME_BITS-1:0] now, input logic chk = 1'b0,
                           input axle_report_t want = '0);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_front_sample <= front;
    in_rear_sample  <= rear;
    in_time_now_ms  <= now;
    poll_check      <= chk;
    poll_want       <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    polls_sent++;
  endtask

  task automatic add_poll(input logic [SB-1:0] front, input logic [SB-1:0] rear,
                          input logic [TIME_BITS-1:0] now, input logic chk = 1'b0,
                          input axle_report_t want = '0);
    axle_poll_t p;
    p.front  = front;
    p.rear   = rear;
    p.now    = now;
    p.check  = chk;
    p.report = want;
    directed_polls.push_back(p);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PRESS_THR:   press_thr = data[SB-1:0];
      CFG_RELEASE_THR: rel_thr = data[SB-1:0];
      CFG_GAP_MIN:     gap_lo = data;
      CFG_GAP_MAX:     gap_hi = data;
      default: ;
    endcase
  endtask

  task automatic program_phase(input int phase);
    logic [CFG_DATA_BITS-1:0] press;
    logic [CFG_DATA_BITS-1:0] rel;
    logic [CFG_DATA_BITS-1:0] lo;
    logic [CFG_DATA_BITS-1:0] hi;
    case (phase)
      0: begin
        press = CFG_DATA_BITS'($urandom_range(3500, 1000));
        rel   = CFG_DATA_BITS'($urandom_range(press));
        lo    = CFG_DATA_BITS'($urandom_range(100));
        hi    = CFG_DATA_BITS'($urandom_range(2000, lo));
      end
      1: begin
        // upper data bits set: threshold keeps only the sample width
        press = '0;
        rel   = '1;
        lo    = '0;
        hi    = '0;
      end
      2: begin
        press = '1;
        rel   = '0;
        lo    = '1;
        hi    = '1;
      end
      3: begin
        // window empty: min above max
        press = 16'd2048;
        rel   = 16'd1024;
        lo    = 16'd500;
        hi    = 16'd100;
      end
      default: begin
        press = CFG_DATA_BITS'($urandom);
        rel   = CFG_DATA_BITS'($urandom);
        lo    = CFG_DATA_BITS'($urandom_range(4000));
        hi    = CFG_DATA_BITS'($urandom_range(lo + 4000, lo));
      end
    endcase
    write_reg(CFG_PRESS_THR, press);
    write_reg(CFG_RELEASE_THR, rel);
    write_reg(CFG_GAP_MIN, lo);
    write_reg(CFG_GAP_MAX, hi);
    // out-of-range index must be dropped
    write_reg(CFG_IDX_BITS'($urandom_range((1 << CFG_IDX_BITS) - 1, CFG_GAP_MAX + 1)),
              CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (axle_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [TIME_BITS-1:0] t0;
    logic [TIME_BITS-1:0] gap;
    int                   target;

    // reset registers: press 2048, release 1024, window 20..1000
    add_poll(12'd4095, 12'd4095, 32'd0, 1'b1, {1'b1, MODE_LOCKED});
    add_poll(12'd2048, 12'd2048, 32'd5, 1'b1, {1'b0, MODE_LOCKED});
    add_poll(12'd1023, 12'd1023, 32'd6, 1'b1, {1'b0, MODE_IDLE});
    add_poll(12'd0, 12'd4095, 32'd10, 1'b1, {1'b0, MODE_IDLE});
    add_poll(12'd2049, 12'd0, 32'd100, 1'b1, {1'b0, MODE_FRONT_HIT});
    add_poll(12'd2049, 12'd4095, 32'd119);
    add_poll(12'd0, 12'd2049, 32'd120, 1'b1, {1'b1, MODE_LOCKED});
    add_poll(12'd1024, 12'd0, 32'd130);
    add_poll(12'd0, 12'd0, 32'd131);
    add_poll(12'd4095, 12'd0, 32'd200);
    add_poll(12'd0, 12'd0, 32'd250);
    add_poll(12'd4095, 12'd0, 32'd300);
    add_poll(12'd4095, 12'd0, 32'd1300);
    add_poll(12'd0, 12'd4095, 32'd1300);
    add_poll(12'd0, 12'd0, 32'd1301);
    add_poll(12'd4095, 12'd0, 32'd1400);
    add_poll(12'd4095, 12'd0, 32'd2401);
    add_poll(12'd0, 12'd0, 32'd2402);
    // wrap of the timestamp inside the window
    add_poll(12'd4095, 12'd0, 32'hFFFF_FFF0);
    add_poll(12'd0, 12'd4095, 32'h0000_0010);
    add_poll(12'd0, 12'd0, 32'h0000_0020);
    // timestamp running backwards looks like a huge gap
    add_poll(12'd4095, 12'd0, 32'd5000);
    add_poll(12'd4095, 12'd4095, 32'd4990);
    add_poll(12'd0, 12'd0, 32'd4991);

    repeat (4) @(posedge clk);
    rst_n  <= 1'b1;
    tx_pct = 19;
    rx_pct <= 57;
    foreach (directed_polls[i])
      send_poll(directed_polls[i].front, directed_polls[i].rear, directed_polls[i].now,
                directed_polls[i].check, directed_polls[i].report);
    in_valid <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      program_phase(phase);
      if (phase < 2) begin
        tx_pct = 19;
        rx_pct <= 57;
      end else if (phase < 4) begin
        tx_pct = 57;
        rx_pct <= 19;
      end else begin
        tx_pct = 0;
        rx_pct <= 0;
      end
      if (phase == 4) hold_tag <= hold_tag + 1;
      target = polls_sent + PHASE_POLLS;
      while (polls_sent < target) begin
        if ($urandom_range(99) < 70) begin
          // one vehicle pass: released, front, maybe more front, rear, maybe random levels, release
          t0 = clock_ms + $urandom_range(50);
          send_poll(pick_sample(0), pick_sample(0), t0 - 1);
          send_poll(pick_sample(1), pick_sample(0), t0);
          case ($urandom_range(5))
            0: gap = TIME_BITS'(gap_lo) - 1;
            1: gap = TIME_BITS'(gap_lo);
            2: gap = TIME_BITS'(gap_hi);
            3: gap = TIME_BITS'(gap_hi) + 1;
            default: gap = $urandom_range(TIME_BITS'(gap_hi) + gap_hi / 2 + 2);
          endcase
          repeat ($urandom_range(2))
            send_poll(pick_sample($urandom_range(1) ? 1 : 3), pick_sample(0),
                      t0 + $urandom_range(gap));
          send_poll(pick_sample($urandom_range(1) ? 1 : 3), pick_sample(1), t0 + gap);
          repeat ($urandom_range(2))
            send_poll(pick_sample(3), pick_sample(3), t0 + gap + 1);
          send_poll(pick_sample(0), pick_sample(0), t0 + gap + 2);
          clock_ms = t0 + gap + 3;
        end else begin
          repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(7) == 0)
              clock_ms = $urandom;
            else
              clock_ms += $urandom_range(2 * TIME_BITS'(gap_hi) + 3);
            send_poll(pick_sample($urandom_range(3)), pick_sample($urandom_range(3)),
                      clock_ms);
          end
        end
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    if (mismatches == 0)
      $display("PASS dual_sensor_axle_detector_core");
    else
      $display("FAIL dual_sensor_axle_detector_core");
    $finish;
  end

endmodule

// ===== dual_sensor_axle_detector_core.f =====
src/dsad_pkg.sv
src/dsad_step.sv
src/dual_sensor_axle_detector_core.sv
tb/dual_sensor_axle_detector_core_tb.sv
